@@ design/hbs_pkg.sv @@
package hbs_pkg;

    localparam int MAX_RESOLUTION = 64;
    localparam int TABLE_DEPTH    = 4096;
    localparam int ADDR_W         = 12;
    localparam int HEIGHT_W       = 32;
    localparam int RES_W          = 7;
    localparam int COORD_W        = $clog2(MAX_RESOLUTION);
    localparam int FRAC_W         = 16;
    localparam int GRID_W         = COORD_W + FRAC_W;
    localparam int QUOT_W         = GRID_W + 1;
    localparam int SIZE_W         = 31;
    localparam int COUNT_W        = 13;

    // Latency of the grid mapper: multiply, range check, one stage per
    // quotient bit, clamp.
    localparam int GMAP_LAT  = QUOT_W + 3;
    localparam int BLEND_LAT = 4;

    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    localparam logic [1:0] CFG_GRID_RESOLUTION = 2'd0;
    localparam logic [1:0] CFG_TERRAIN_SIZE_X  = 2'd1;
    localparam logic [1:0] CFG_TERRAIN_SIZE_Z  = 2'd2;
    localparam logic [1:0] CFG_LOADED_COUNT    = 2'd3;

    typedef struct packed {
        logic                valid;
        logic                cmd;
        logic [ADDR_W-1:0]   idx;
        logic [HEIGHT_W-1:0] height;
    } t_tag;

endpackage

@@ design/hbs_ram.sv @@
module hbs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ design/hbs_grid_map.sv @@
module hbs_grid_map
    import hbs_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [31:0] i_pos,
    input  logic [SIZE_W-1:0]  i_size,
    input  logic [COORD_W-1:0] i_res_m1,
    output logic [GRID_W-1:0]  o_grid
);

    localparam int PROD_W = SIZE_W + COORD_W;
    localparam int NUM_W  = PROD_W + FRAC_W;
    localparam int CMP_W  = NUM_W + 1;

    logic [PROD_W-1:0] r_prod;
    logic [NUM_W-1:0]  r_rem [QUOT_W+1];
    logic [NUM_W-1:0]  n_rem [QUOT_W+1];
    logic [QUOT_W-1:0] r_q   [QUOT_W+1];
    logic [QUOT_W-1:0] n_q   [QUOT_W+1];
    logic              r_ovf [QUOT_W+1];
    logic [GRID_W-1:0] r_grid;
    logic [NUM_W-1:0]  num;
    logic              ovf;
    logic [GRID_W-1:0] top;
    logic [CMP_W-1:0]  dvs;

    assign num = {r_prod, {FRAC_W{1'b0}}};
    assign ovf = {1'b0, num} >= {i_size, {QUOT_W{1'b0}}};
    assign top = {i_res_m1, {FRAC_W{1'b0}}};

    // Restoring division, one quotient bit per stage, most significant first.
    always_comb begin
        n_rem[0] = num;
        n_q[0]   = '0;
        dvs      = '0;
        for (int k = 0; k < QUOT_W; k++) begin
            dvs = CMP_W'(i_size) << (QUOT_W - 1 - k);
            if ({1'b0, r_rem[k]} >= dvs) begin
                n_rem[k+1] = r_rem[k] - dvs[NUM_W-1:0];
                n_q[k+1]   = {r_q[k][QUOT_W-2:0], 1'b1};
            end else begin
                n_rem[k+1] = r_rem[k];
                n_q[k+1]   = {r_q[k][QUOT_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod   <= (i_pos > 0) ? PROD_W'(i_pos[SIZE_W-1:0]) * PROD_W'(i_res_m1) : '0;
            r_rem[0] <= n_rem[0];
            r_q[0]   <= n_q[0];
            r_ovf[0] <= ovf;
            for (int k = 0; k < QUOT_W; k++) begin
                r_rem[k+1] <= n_rem[k+1];
                r_q[k+1]   <= n_q[k+1];
                r_ovf[k+1] <= r_ovf[k];
            end
            if (r_ovf[QUOT_W] || (r_q[QUOT_W] > QUOT_W'(top))) begin
                r_grid <= top;
            end else begin
                r_grid <= r_q[QUOT_W][GRID_W-1:0];
            end
        end
    end

    assign o_grid = r_grid;

endmodule

@@ design/hbs_blend.sv @@
module hbs_blend
    import hbs_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic signed [HEIGHT_W-1:0] i_h00,
    input  logic signed [HEIGHT_W-1:0] i_h10,
    input  logic signed [HEIGHT_W-1:0] i_h01,
    input  logic signed [HEIGHT_W-1:0] i_h11,
    input  logic [FRAC_W-1:0]          i_fx,
    input  logic [FRAC_W-1:0]          i_fz,
    output logic signed [HEIGHT_W-1:0] o_height
);

    localparam int DIFF_W = HEIGHT_W + 1;
    localparam int PROD_W = DIFF_W + FRAC_W + 1;

    logic signed [DIFF_W-1:0]   d_top, d_bot, d_z;
    logic signed [PROD_W-1:0]   r_p_top, r_p_bot, r_p_z;
    logic signed [HEIGHT_W-1:0] r_h00, r_h01, r_top, r_bot, r_top2, r_out;
    logic [FRAC_W-1:0]          r_fz1, r_fz2;
    logic signed [PROD_W-1:0]   s_top, s_bot, s_z;

    assign d_top = DIFF_W'(i_h10) - DIFF_W'(i_h00);
    assign d_bot = DIFF_W'(i_h11) - DIFF_W'(i_h01);
    assign d_z   = DIFF_W'(r_bot) - DIFF_W'(r_top);
    assign s_top = r_p_top >>> FRAC_W;
    assign s_bot = r_p_bot >>> FRAC_W;
    assign s_z   = r_p_z >>> FRAC_W;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // row blends along X
            r_p_top <= PROD_W'(d_top) * $signed({1'b0, i_fx});
            r_p_bot <= PROD_W'(d_bot) * $signed({1'b0, i_fx});
            r_h00   <= i_h00;
            r_h01   <= i_h01;
            r_fz1   <= i_fz;
            r_top   <= r_h00 + HEIGHT_W'(s_top);
            r_bot   <= r_h01 + HEIGHT_W'(s_bot);
            r_fz2   <= r_fz1;
            // column blend along Z
            r_p_z   <= PROD_W'(d_z) * $signed({1'b0, r_fz2});
            r_top2  <= r_top;
            r_out   <= r_top2 + HEIGHT_W'(s_z);
        end
    end

    assign o_height = r_out;

endmodule

@@ design/heightmap_bilinear_sampler_core.sv @@
// Heightmap bilinear sampler. A write beat (command 0) stores one signed
// Q16.16 height at entry_index; a sample beat (command 1) maps world_x and
// world_z to grid space as position * (resolution - 1) / size, clamps to the
// grid, reads the four neighbors and returns their bilinear blend, floored,
// in Q16.16. Writes give no result; each sample gives exactly one. The block
// takes one beat per cycle whenever the result register is free or being
// drained; a result is offered once its sample beat has passed the input
// register, the two position mappers (26 stages each: multiply, range check,
// 23 quotient stages, clamp), the address stage, the table read and the
// four-stage blend. The height table is held four times over, one 4096 x 32
// RAM per neighbor, every write going to all four, so the four reads issue
// together. Writes travel the same pipeline as samples and hit the table
// at the read stage, so every sample sees exactly the writes accepted before
// it. Special cases: resolution 0 or loaded_count 0 gives 0; resolution 1 or
// a zero size gives entry 0; entries at or above loaded_count read as 0;
// resolution above 64 acts as 64. The user must write configuration registers
// only while no beat is in flight; the block itself does not enforce it.
module heightmap_bilinear_sampler_core
    import hbs_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic                       i_command,
    input  logic [ADDR_W-1:0]          i_entry_index,
    input  logic signed [HEIGHT_W-1:0] i_entry_height,
    input  logic signed [31:0]         i_world_x,
    input  logic signed [31:0]         i_world_z,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic signed [HEIGHT_W-1:0] o_sampled_height,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [1:0]                 i_cfg_index,
    input  logic [SIZE_W-1:0]          i_cfg_data
);

    // Configuration registers.
    logic [RES_W-1:0]   r_res;
    logic [SIZE_W-1:0]  r_size_x, r_size_z;
    logic [COUNT_W-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res    <= '0;
            r_size_x <= '0;
            r_size_z <= '0;
            r_count  <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_GRID_RESOLUTION: r_res    <= i_cfg_data[RES_W-1:0];
                CFG_TERRAIN_SIZE_X:  r_size_x <= i_cfg_data;
                CFG_TERRAIN_SIZE_Z:  r_size_z <= i_cfg_data;
                CFG_LOADED_COUNT:    r_count  <= i_cfg_data[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // The whole pipeline advances together; it holds only when a result
    // waits in the output register and is not taken.
    logic adv;
    logic r_ov, r_oc;
    assign adv        = !(r_ov && r_oc == CMD_SAMPLE) || i_out_ready;
    assign o_in_ready = adv;

    logic [RES_W-1:0]   res_eff;
    logic [COORD_W-1:0] res_m1;
    assign res_eff = (r_res > RES_W'(MAX_RESOLUTION)) ? RES_W'(MAX_RESOLUTION) : r_res;
    assign res_m1  = COORD_W'(res_eff - RES_W'(1));

    // Input register.
    t_tag               r_in_tag;
    logic signed [31:0] r_x, r_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_tag.valid <= 1'b0;
        end else if (adv) begin
            r_in_tag.valid <= i_in_valid;
        end
        if (adv) begin
            r_in_tag.cmd    <= i_command;
            r_in_tag.idx    <= i_entry_index;
            r_in_tag.height <= i_entry_height;
            r_x             <= i_world_x;
            r_z             <= i_world_z;
        end
    end

    // Grid mapping for both axes.
    logic [GRID_W-1:0] gx, gz;

    hbs_grid_map u_map_x (
        .i_clk    (i_clk),
        .i_en     (adv),
        .i_pos    (r_x),
        .i_size   (r_size_x),
        .i_res_m1 (res_m1),
        .o_grid   (gx)
    );

    hbs_grid_map u_map_z (
        .i_clk    (i_clk),
        .i_en     (adv),
        .i_pos    (r_z),
        .i_size   (r_size_z),
        .i_res_m1 (res_m1),
        .o_grid   (gz)
    );

    // Carry the beat alongside the mapper.
    t_tag r_tag [GMAP_LAT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < GMAP_LAT; k++) begin
                r_tag[k].valid <= 1'b0;
            end
        end else if (adv) begin
            r_tag[0].valid <= r_in_tag.valid;
            for (int k = 1; k < GMAP_LAT; k++) begin
                r_tag[k].valid <= r_tag[k-1].valid;
            end
        end
        if (adv) begin
            r_tag[0].cmd    <= r_in_tag.cmd;
            r_tag[0].idx    <= r_in_tag.idx;
            r_tag[0].height <= r_in_tag.height;
            for (int k = 1; k < GMAP_LAT; k++) begin
                r_tag[k].cmd    <= r_tag[k-1].cmd;
                r_tag[k].idx    <= r_tag[k-1].idx;
                r_tag[k].height <= r_tag[k-1].height;
            end
        end
    end

    // Neighbor addressing.
    logic               no_terrain, single;
    logic [GRID_W-1:0]  gxu, gzu;
    logic [COORD_W-1:0] x0, z0, x1, z1;
    logic [RES_W-1:0]   x0p, z0p;
    logic [ADDR_W-1:0]  a00, a10, a01, a11;

    function automatic logic [ADDR_W-1:0] grid_addr(
        input logic [COORD_W-1:0] z,
        input logic [COORD_W-1:0] x,
        input logic [RES_W-1:0]   res
    );
        logic [COUNT_W-1:0] sum;
        sum = COUNT_W'(z) * COUNT_W'(res) + COUNT_W'(x);
        return sum[ADDR_W-1:0];
    endfunction

    assign no_terrain = (res_eff == '0) || (r_count == '0);
    assign single     = (res_eff == RES_W'(1)) || (r_size_x == '0) || (r_size_z == '0);
    assign gxu        = single ? '0 : gx;
    assign gzu        = single ? '0 : gz;
    assign x0         = gxu[GRID_W-1:FRAC_W];
    assign z0         = gzu[GRID_W-1:FRAC_W];
    assign x0p        = RES_W'(x0) + RES_W'(1);
    assign z0p        = RES_W'(z0) + RES_W'(1);
    assign x1         = (x0p < res_eff) ? x0p[COORD_W-1:0] : res_m1;
    assign z1         = (z0p < res_eff) ? z0p[COORD_W-1:0] : res_m1;
    assign a00        = grid_addr(z0, x0, res_eff);
    assign a10        = grid_addr(z0, x1, res_eff);
    assign a01        = grid_addr(z1, x0, res_eff);
    assign a11        = grid_addr(z1, x1, res_eff);

    t_tag              r_a_tag;
    logic [ADDR_W-1:0] r_a00, r_a10, r_a01, r_a11;
    logic [3:0]        r_a_in;
    logic              r_a_zero;
    logic [FRAC_W-1:0] r_a_fx, r_a_fz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_tag.valid <= 1'b0;
        end else if (adv) begin
            r_a_tag.valid <= r_tag[GMAP_LAT-1].valid;
        end
        if (adv) begin
            r_a_tag.cmd    <= r_tag[GMAP_LAT-1].cmd;
            r_a_tag.idx    <= r_tag[GMAP_LAT-1].idx;
            r_a_tag.height <= r_tag[GMAP_LAT-1].height;
            r_a00          <= a00;
            r_a10          <= a10;
            r_a01          <= a01;
            r_a11          <= a11;
            r_a_in         <= {{1'b0, a11} < r_count, {1'b0, a01} < r_count,
                               {1'b0, a10} < r_count, {1'b0, a00} < r_count};
            r_a_zero       <= no_terrain;
            r_a_fx         <= gxu[FRAC_W-1:0];
            r_a_fz         <= gzu[FRAC_W-1:0];
        end
    end

    // Table: one copy per neighbor. Writes land here, in beat order.
    logic                wr_en;
    logic [HEIGHT_W-1:0] d00, d10, d01, d11;

    assign wr_en = adv && r_a_tag.valid && (r_a_tag.cmd == CMD_WRITE);

    hbs_ram #(.WIDTH(HEIGHT_W), .DEPTH(TABLE_DEPTH)) u_ram00 (
        .i_clk(i_clk), .i_wr_en(wr_en), .i_wr_addr(r_a_tag.idx),
        .i_wr_data(r_a_tag.height), .i_rd_en(adv), .i_rd_addr(r_a00), .o_rd_data(d00)
    );
    hbs_ram #(.WIDTH(HEIGHT_W), .DEPTH(TABLE_DEPTH)) u_ram10 (
        .i_clk(i_clk), .i_wr_en(wr_en), .i_wr_addr(r_a_tag.idx),
        .i_wr_data(r_a_tag.height), .i_rd_en(adv), .i_rd_addr(r_a10), .o_rd_data(d10)
    );
    hbs_ram #(.WIDTH(HEIGHT_W), .DEPTH(TABLE_DEPTH)) u_ram01 (
        .i_clk(i_clk), .i_wr_en(wr_en), .i_wr_addr(r_a_tag.idx),
        .i_wr_data(r_a_tag.height), .i_rd_en(adv), .i_rd_addr(r_a01), .o_rd_data(d01)
    );
    hbs_ram #(.WIDTH(HEIGHT_W), .DEPTH(TABLE_DEPTH)) u_ram11 (
        .i_clk(i_clk), .i_wr_en(wr_en), .i_wr_addr(r_a_tag.idx),
        .i_wr_data(r_a_tag.height), .i_rd_en(adv), .i_rd_addr(r_a11), .o_rd_data(d11)
    );

    // Read stage: drop entries past the loaded count, or all on no terrain.
    logic              r_r_valid, r_r_cmd, r_r_zero;
    logic [3:0]        r_r_in;
    logic [FRAC_W-1:0] r_r_fx, r_r_fz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_r_valid <= 1'b0;
        end else if (adv) begin
            r_r_valid <= r_a_tag.valid;
        end
        if (adv) begin
            r_r_cmd  <= r_a_tag.cmd;
            r_r_zero <= r_a_zero;
            r_r_in   <= r_a_in;
            r_r_fx   <= r_a_fx;
            r_r_fz   <= r_a_fz;
        end
    end

    logic signed [HEIGHT_W-1:0] h00, h10, h01, h11;
    assign h00 = (r_r_in[0] && !r_r_zero) ? d00 : '0;
    assign h10 = (r_r_in[1] && !r_r_zero) ? d10 : '0;
    assign h01 = (r_r_in[2] && !r_r_zero) ? d01 : '0;
    assign h11 = (r_r_in[3] && !r_r_zero) ? d11 : '0;

    hbs_blend u_blend (
        .i_clk    (i_clk),
        .i_en     (adv),
        .i_h00    (h00),
        .i_h10    (h10),
        .i_h01    (h01),
        .i_h11    (h11),
        .i_fx     (r_r_fx),
        .i_fz     (r_r_fz),
        .o_height (o_sampled_height)
    );

    // Beat flags through the blend; the last one marks the output register.
    logic r_bv [BLEND_LAT-1];
    logic r_bc [BLEND_LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < BLEND_LAT - 1; k++) begin
                r_bv[k] <= 1'b0;
            end
            r_ov <= 1'b0;
        end else if (adv) begin
            r_bv[0] <= r_r_valid;
            for (int k = 1; k < BLEND_LAT - 1; k++) begin
                r_bv[k] <= r_bv[k-1];
            end
            r_ov <= r_bv[BLEND_LAT-2];
        end
        if (adv) begin
            r_bc[0] <= r_r_cmd;
            for (int k = 1; k < BLEND_LAT - 1; k++) begin
                r_bc[k] <= r_bc[k-1];
            end
            r_oc <= r_bc[BLEND_LAT-2];
        end
    end

    assign o_out_valid = r_ov && (r_oc == CMD_SAMPLE);

endmodule

@@ design/hbs_checker.sv @@
module hbs_checker
    import hbs_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_in_ready,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input logic [HEIGHT_W-1:0] o_sampled_height,
    input logic                o_cfg_ready
);

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its value.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_sampled_height))
        else $error("result changed while stalled");

    // Input side stalls only behind a waiting result.
    a_in_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready == (!o_out_valid || i_out_ready))
        else $error("input ready does not follow output side");

    // No result right after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result offered after reset");

    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready)
        else $error("configuration port stalled");

endmodule

bind heightmap_bilinear_sampler_core hbs_checker u_hbs_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_in_ready       (o_in_ready),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .o_sampled_height (o_sampled_height),
    .o_cfg_ready      (o_cfg_ready)
);
